// ===== rtl/osa_pkg.sv =====
// Package for the ordered slot allocator: sizes, mode codes, register map.
// No dependencies; used by the channel interfaces and the top level.

package osa_pkg;

   localparam int SLOTS  = 4;
   localparam int IDX_W  = $clog2(SLOTS);
   localparam int CNT_W  = 3;
   localparam int BLK_W  = 3;
   localparam int POS_W  = 8;
   localparam int ADDR_W = 16;
   localparam int CFG_W  = 8;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   typedef enum logic [1:0] {
      MODE_SAVE   = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_LOOKUP = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   // register index taken from paddr[2]
   localparam logic REG_SLOT_BYTES  = 1'b0;
   localparam logic REG_TEXT_OFFSET = 1'b1;

   localparam logic [CFG_W-1:0] SLOT_BYTES_RST  = 8'd120;
   localparam logic [CFG_W-1:0] TEXT_OFFSET_RST = 8'd8;

endpackage

// ===== rtl/osa_req_if.sv =====
// Request channel of the ordered slot allocator: valid/ready plus mode and position.
// Depends on osa_pkg.

interface osa_req_if import osa_pkg::*;;
   logic             valid;
   logic             ready;
   mode_type         mode;
   logic [POS_W-1:0] position;

   modport source (output valid, output mode, output position, input ready);
   modport sink   (input valid, input mode, input position, output ready);
endinterface

// ===== rtl/osa_rsp_if.sv =====
// Response channel of the ordered slot allocator: valid/ready plus result fields.
// Depends on osa_pkg.

interface osa_rsp_if import osa_pkg::*;;
   logic              valid;
   logic              ready;
   logic              ok;
   logic [BLK_W-1:0]  block;
   logic [ADDR_W-1:0] header_addr;
   logic [ADDR_W-1:0] body_addr;
   logic [CNT_W-1:0]  count;
   logic              full_res;
   logic              empty_res;

   modport source (output valid, output ok, output block, output header_addr,
                   output body_addr, output count, output full_res, output empty_res,
                   input ready);
   modport sink   (input valid, input ok, input block, input header_addr,
                   input body_addr, input count, input full_res, input empty_res,
                   output ready);
endinterface

// ===== rtl/ordered_slot_allocator.sv =====
// Ordered slot allocator top level: age-ordered block list, sequencer, CSRs.
// Depends on osa_pkg, osa_req_if, osa_rsp_if.
//
//   channel   dir   handshake              payload
//   req_chan  in    valid/ready            mode, position
//   rsp_chan  out   valid/ready            ok, block, header_addr, body_addr,
//                                          count, full_res, empty_res
//   csr_*     in    APB, pready tied high  slot_bytes @0x0, text_offset @0x4
//
// One request at a time; the list is walked one entry per cycle through a
// single read port. Save scans the stored entries and picks a block, delete
// fetches the entry and moves each later entry down, lookup fetches it; every
// request, clear and failing ones too, then multiplies, adds and loads the
// result. The next request is taken in the idle cycle that follows.
// Reset (synchronous) empties the list and restores the register defaults.
// A result waits in the output register; the next request is taken meanwhile
// and stalls only at its final step until the previous result transfers.

module ordered_slot_allocator import osa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   osa_req_if.sink           req_chan,
   osa_rsp_if.source         rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_PICK, ST_FETCH, ST_SHIFT, ST_MUL, ST_ADD, ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   mode_type          mode_ff, mode_in;
   logic [IDX_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SLOTS-1:0]  used_ff, used_in;
   logic [BLK_W-1:0]  blk_ff, blk_in;
   logic              ok_ff, ok_in;
   logic [ADDR_W-1:0] hdr_ff, hdr_in;
   logic [ADDR_W-1:0] txt_ff, txt_in;

   logic [BLK_W-1:0]  list_ff [SLOTS];
   logic              list_we;
   logic [IDX_W-1:0]  list_wa;
   logic [BLK_W-1:0]  list_wd;
   logic [IDX_W-1:0]  rd_addr;
   logic [BLK_W-1:0]  rd_data;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [BLK_W-1:0]  rsp_block_ff, rsp_block_in;
   logic [ADDR_W-1:0] rsp_hdr_ff, rsp_hdr_in;
   logic [ADDR_W-1:0] rsp_txt_ff, rsp_txt_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic [CFG_W-1:0]  slot_bytes_ff, slot_bytes_in;
   logic [CFG_W-1:0]  text_offset_ff, text_offset_in;
   logic              csr_wr;

   logic [BLK_W-1:0]  pick_blk;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      slot_bytes_in  = slot_bytes_ff;
      text_offset_in = text_offset_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_SLOT_BYTES:  slot_bytes_in  = csr_pwdata[CFG_W-1:0];
            REG_TEXT_OFFSET: text_offset_in = csr_pwdata[CFG_W-1:0];
            default:         slot_bytes_in  = slot_bytes_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_SLOT_BYTES:  csr_prdata = CSR_DW'(slot_bytes_ff);
         REG_TEXT_OFFSET: csr_prdata = CSR_DW'(text_offset_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // ---------------- list read port ----------------
   assign rd_data = list_ff[rd_addr];

   // lowest block number not marked used
   always_comb begin
      pick_blk = '0;
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (!used_ff[s]) pick_blk = BLK_W'(s + 1);
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      ptr_in       = ptr_ff;
      count_in     = count_ff;
      used_in      = used_ff;
      blk_in       = blk_ff;
      ok_in        = ok_ff;
      hdr_in       = hdr_ff;
      txt_in       = txt_ff;
      list_we      = 1'b0;
      list_wa      = ptr_ff;
      list_wd      = rd_data;
      rd_addr      = ptr_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_block_in = rsp_block_ff;
      rsp_hdr_in   = rsp_hdr_ff;
      rsp_txt_in   = rsp_txt_ff;
      rsp_count_in = rsp_count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               mode_in = req_chan.mode;
               blk_in  = '0;
               ok_in   = 1'b0;
               used_in = '0;
               ptr_in  = '0;
               unique case (req_chan.mode)
                  MODE_SAVE: begin
                     if (count_ff == CNT_W'(SLOTS)) state_in = ST_MUL;
                     else if (count_ff == '0)      state_in = ST_PICK;
                     else                          state_in = ST_SCAN;
                  end
                  MODE_DELETE, MODE_LOOKUP: begin
                     if (req_chan.position >= POS_W'(count_ff)) begin
                        state_in = ST_MUL;
                     end else begin
                        ptr_in   = req_chan.position[IDX_W-1:0];
                        state_in = ST_FETCH;
                     end
                  end
                  MODE_CLEAR: begin
                     count_in = '0;
                     ok_in    = 1'b1;
                     state_in = ST_MUL;
                  end
                  default: state_in = ST_MUL;
               endcase
            end
         end
         ST_SCAN: begin
            for (int s = 0; s < SLOTS; s++) begin
               if (rd_data == BLK_W'(s + 1)) used_in[s] = 1'b1;
            end
            ptr_in = ptr_ff + 1'b1;
            if (CNT_W'(ptr_ff) + CNT_W'(1) == count_ff) state_in = ST_PICK;
         end
         ST_PICK: begin
            blk_in   = pick_blk;
            ok_in    = 1'b1;
            list_we  = 1'b1;
            list_wa  = count_ff[IDX_W-1:0];
            list_wd  = pick_blk;
            count_in = count_ff + 1'b1;
            state_in = ST_MUL;
         end
         ST_FETCH: begin
            blk_in = rd_data;
            ok_in  = 1'b1;
            if (mode_ff == MODE_LOOKUP) begin
               state_in = ST_MUL;
            end else if (CNT_W'(ptr_ff) + CNT_W'(1) == count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = ST_MUL;
            end else begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            // move the next entry down one place
            rd_addr = ptr_ff + 1'b1;
            list_we = 1'b1;
            list_wa = ptr_ff;
            list_wd = rd_data;
            ptr_in  = ptr_ff + 1'b1;
            if (CNT_W'(ptr_ff) + CNT_W'(2) == count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (blk_ff == '0) hdr_in = '0;
            else hdr_in = ADDR_W'(ADDR_W'(blk_ff - BLK_W'(1)) * ADDR_W'(slot_bytes_ff));
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (blk_ff == '0) txt_in = '0;
            else txt_in = hdr_ff + ADDR_W'(text_offset_ff);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_block_in = blk_ff;
               rsp_hdr_in   = hdr_ff;
               rsp_txt_in   = txt_ff;
               rsp_count_in = count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         slot_bytes_ff  <= SLOT_BYTES_RST;
         text_offset_ff <= TEXT_OFFSET_RST;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
         slot_bytes_ff  <= slot_bytes_in;
         text_offset_ff <= text_offset_in;
      end
      mode_ff      <= mode_in;
      ptr_ff       <= ptr_in;
      used_ff      <= used_in;
      blk_ff       <= blk_in;
      ok_ff        <= ok_in;
      hdr_ff       <= hdr_in;
      txt_ff       <= txt_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_block_ff <= rsp_block_in;
      rsp_hdr_ff   <= rsp_hdr_in;
      rsp_txt_ff   <= rsp_txt_in;
      rsp_count_ff <= rsp_count_in;
   end

   // entries at or beyond the count are never read, so no clearing is needed
   always_ff @(posedge clock) begin
      if (list_we) list_ff[list_wa] <= list_wd;
   end

   // ---------------- channel outputs ----------------
   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.ok          = rsp_ok_ff;
   assign rsp_chan.block       = rsp_block_ff;
   assign rsp_chan.header_addr = rsp_hdr_ff;
   assign rsp_chan.body_addr   = rsp_txt_ff;
   assign rsp_chan.count       = rsp_count_ff;
   assign rsp_chan.full_res    = (rsp_count_ff == CNT_W'(SLOTS));
   assign rsp_chan.empty_res   = (rsp_count_ff == '0);

endmodule

// ===== tb/osa_tb_pkg.sv =====
// Checker class for the ordered slot allocator testbench: keeps its own copy of
// the block list and registers and compares every response transfer in order.
// Depends on osa_pkg.

package osa_tb_pkg;
   import osa_pkg::*;

   typedef struct packed {
      logic              ok;
      logic [BLK_W-1:0]  block;
      logic [ADDR_W-1:0] header_addr;
      logic [ADDR_W-1:0] body_addr;
      logic [CNT_W-1:0]  count;
      logic              full_res;
      logic              empty_res;
   } slot_result_type;

   class slot_order_checker;
      logic [BLK_W-1:0] slots [SLOTS];
      int               stored;
      logic [CFG_W-1:0] slot_bytes;
      logic [CFG_W-1:0] text_offset;
      slot_result_type  expected_results [$];
      int               mismatches;
      int               checked;

      function new();
         foreach (slots[i]) slots[i] = '0;
         stored      = 0;
         slot_bytes  = SLOT_BYTES_RST;
         text_offset = TEXT_OFFSET_RST;
         mismatches  = 0;
         checked     = 0;
      endfunction

      function void set_register(logic reg_idx, logic [CFG_W-1:0] value);
         if (reg_idx == REG_SLOT_BYTES)
            slot_bytes = value;
         else
            text_offset = value;
      endfunction

      // update the list for one accepted request and queue the response it yields
      function void apply_request(mode_type mode, logic [POS_W-1:0] position);
         slot_result_type r;
         logic [BLK_W-1:0] blk;
         logic ok;
         bit used;
         int unsigned hdr;
         blk = '0;
         ok  = 1'b0;
         case (mode)
            MODE_SAVE: begin
               if (stored < SLOTS) begin
                  for (int b = 1; b <= SLOTS && blk == 0; b++) begin
                     used = 1'b0;
                     for (int i = 0; i < stored; i++)
                        if (slots[i] == b) used = 1'b1;
                     if (!used) blk = BLK_W'(b);
                  end
                  if (blk != 0) begin
                     slots[stored] = blk;
                     stored++;
                     ok = 1'b1;
                  end
               end
            end
            MODE_DELETE: begin
               if (position < stored) begin
                  blk = slots[position];
                  for (int i = position + 1; i < stored; i++)
                     slots[i-1] = slots[i];
                  slots[stored-1] = '0;
                  stored--;
                  ok = 1'b1;
               end
            end
            MODE_LOOKUP: begin
               if (position < stored) begin
                  blk = slots[position];
                  ok  = 1'b1;
               end
            end
            default: begin
               foreach (slots[i]) slots[i] = '0;
               stored = 0;
               ok     = 1'b1;
            end
         endcase
         r.ok    = ok;
         r.block = blk;
         if (blk != 0) begin
            hdr           = (int'(blk) - 1) * int'(slot_bytes);
            r.header_addr = hdr[ADDR_W-1:0];
            r.body_addr   = ADDR_W'(hdr + int'(text_offset));
         end else begin
            r.header_addr = '0;
            r.body_addr   = '0;
         end
         r.count     = CNT_W'(stored);
         r.full_res  = (stored == SLOTS);
         r.empty_res = (stored == 0);
         expected_results.push_back(r);
      endfunction

      function void check_result(slot_result_type seen);
         slot_result_type want;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: response transfer with nothing pending: ok=%0b blk=%0d",
                        seen.ok, seen.block);
            return;
         end
         want = expected_results.pop_front();
         checked++;
         if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: response %0d: exp ok=%0b blk=%0d hdr=%0d txt=%0d cnt=%0d full=%0b empty=%0b",
                        checked, want.ok, want.block, want.header_addr, want.body_addr,
                        want.count, want.full_res, want.empty_res);
               $display("ERROR: response %0d: got ok=%0b blk=%0d hdr=%0d txt=%0d cnt=%0d full=%0b empty=%0b",
                        checked, seen.ok, seen.block, seen.header_addr, seen.body_addr,
                        seen.count, seen.full_res, seen.empty_res);
            end
         end
      endfunction
   endclass

endpackage

// ===== tb/tb_top.sv =====
// Top level testbench for the ordered slot allocator: drives requests and APB
// register writes, paces both channels, checks responses through osa_tb_pkg.
// Depends on osa_pkg, osa_req_if, osa_rsp_if, osa_tb_pkg and the block itself.

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import osa_pkg::*;
   import osa_tb_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int PHASES       = 6;
   localparam int ITEMS_PER_PH = 90;

   logic              clock;
   logic              reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   osa_req_if req_chan ();
   osa_rsp_if rsp_chan ();

   ordered_slot_allocator u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   slot_order_checker board = new();
   slot_result_type   seen;
   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;
   int                requests_sent = 0;
   int                settings_used = 1;
   int                cycles = 0;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(negedge clock)
      rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen.ok          = rsp_chan.ok;
         seen.block       = rsp_chan.block;
         seen.header_addr = rsp_chan.header_addr;
         seen.body_addr   = rsp_chan.body_addr;
         seen.count       = rsp_chan.count;
         seen.full_res    = rsp_chan.full_res;
         seen.empty_res   = rsp_chan.empty_res;
         board.check_result(seen);
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL ordered_slot_allocator");
      $finish;
   end

   // called and returns at a falling edge; valid stays up for a back-to-back transfer
   task automatic send_request(input mode_type mode, input logic [POS_W-1:0] position);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.mode     <= mode;
      req_chan.position <= position;
      do @(posedge clock); while (!req_chan.ready);
      board.apply_request(mode, position);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic send_random_request();
      mode_type         mode;
      logic [POS_W-1:0] position;
      int               pick;
      pick = $urandom_range(99);
      if (pick < 38)
         mode = MODE_SAVE;
      else if (pick < 65)
         mode = MODE_DELETE;
      else if (pick < 95)
         mode = MODE_LOOKUP;
      else
         mode = MODE_CLEAR;
      // mostly positions around the live range, now and then anything
      if ($urandom_range(9) < 8)
         position = POS_W'($urandom_range(board.stored));
      else
         position = POS_W'($urandom_range(255));
      send_request(mode, position);
   endtask

   task automatic write_register(input logic reg_idx, input logic [CFG_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_idx, 2'b00};
      csr_pwdata  <= {{(CSR_DW-CFG_W){1'b0}}, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.set_register(reg_idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain_responses();
      while (board.expected_results.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   initial begin
      logic [CFG_W-1:0] sb;
      logic [CFG_W-1:0] toff;
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.mode     <= MODE_SAVE;
      req_chan.position <= '0;
      csr_psel          <= 1'b0;
      csr_penable       <= 1'b0;
      csr_pwrite        <= 1'b0;
      csr_paddr         <= '0;
      csr_pwdata        <= '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty list, fill past full, middle/last/first delete, clear
      send_request(MODE_LOOKUP, 8'd0);
      send_request(MODE_DELETE, 8'd255);
      repeat (5) send_request(MODE_SAVE, 8'd0);
      for (int i = 0; i < 4; i++) send_request(MODE_LOOKUP, POS_W'(i));
      send_request(MODE_LOOKUP, 8'd4);
      send_request(MODE_LOOKUP, 8'd255);
      send_request(MODE_DELETE, 8'd1);
      send_request(MODE_SAVE, 8'd170);
      send_request(MODE_LOOKUP, 8'd3);
      send_request(MODE_DELETE, 8'd4);
      send_request(MODE_DELETE, 8'd3);
      send_request(MODE_DELETE, 8'd0);
      send_request(MODE_LOOKUP, 8'd0);
      send_request(MODE_CLEAR, 8'd85);
      send_request(MODE_LOOKUP, 8'd0);
      send_request(MODE_SAVE, 8'd0);
      send_request(MODE_CLEAR, 8'd0);
      send_request(MODE_CLEAR, 8'd0);

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph > 0) begin
            req_chan.valid <= 1'b0;
            drain_responses();
            case (ph)
               1:       begin sb = 8'd1;   toff = 8'd0;   end
               2:       begin sb = 8'd255; toff = 8'd255; end
               3:       begin sb = 8'd0;   toff = 8'd200; end
               default: begin
                  sb   = CFG_W'($urandom_range(255));
                  toff = CFG_W'($urandom_range(255));
               end
            endcase
            write_register(REG_SLOT_BYTES, sb);
            write_register(REG_TEXT_OFFSET, toff);
            settings_used++;
         end
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
         endcase
         repeat (ITEMS_PER_PH) send_random_request();
      end

      req_chan.valid <= 1'b0;
      while (board.expected_results.size() != 0)
         @(negedge clock);
      repeat (20) @(negedge clock);

      $display("Summary: %0d requests sent, %0d responses checked, %0d mismatches",
               requests_sent, board.checked, board.mismatches);
      $display("Summary: %0d register settings, four pacing modes on both channels",
               settings_used);
      if (board.mismatches == 0 && board.expected_results.size() == 0)
         $display("PASS ordered_slot_allocator");
      else
         $display("FAIL ordered_slot_allocator");
      $finish;
   end

endmodule
